// ===== rtl/v3alu_pkg.sv =====
// Shared types and constants for the three-component fixed-point vector unit.
`default_nettype none

package v3alu_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int SQRT_STAGES   = 32;  // one result bit per stage, 64-bit radicand

    typedef enum logic [2:0] {
        OP_ADD   = 3'd0,
        OP_SUB   = 3'd1,
        OP_DOT   = 3'd2,
        OP_CROSS = 3'd3,
        OP_SCALE = 3'd4,
        OP_DIV_S = 3'd5,
        OP_S_DIV = 3'd6,
        OP_NORM  = 3'd7
    } op_t;

    typedef struct packed {
        op_t                func;
        logic signed [31:0] ax;
        logic signed [31:0] ay;
        logic signed [31:0] az;
        logic signed [31:0] bx;
        logic signed [31:0] by_comp;
        logic signed [31:0] bz;
        logic signed [31:0] scalar;
    } v3_req_t;

    typedef struct packed {
        logic signed [31:0] rx;
        logic signed [31:0] ry;
        logic signed [31:0] rz;
        logic               div_zero;
        logic               overflow;
    } v3_rsp_t;

    // Per-request bookkeeping that rides down the pipe.
    typedef struct packed {
        op_t              func;
        logic [2:0][31:0] a;
        logic [31:0]      s;
        logic [2:0][31:0] r;         // result of the non-divide ops
        logic             ov;
        logic             sq_zero;
        logic [2:0]       neg;       // quotient sign
        logic [2:0]       num_neg;
        logic [2:0]       num_zero;
        logic [2:0]       den_zero;
    } v3_pl_t;

endpackage

`default_nettype wire

// ===== rtl/v3alu_div_lane.sv =====
// Pipelined restoring divider, one quotient bit per stage.
`default_nettype none

module v3alu_div_lane #(
    parameter int NUM_W = 49,
    parameter int DEN_W = 33
)(
    input  logic             clk,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic [NUM_W-1:0] quo
);

    logic [NUM_W-1:0] n_reg [NUM_W];
    logic [NUM_W-1:0] q_reg [NUM_W];
    logic [DEN_W-1:0] r_reg [NUM_W];
    logic [DEN_W-1:0] d_reg [NUM_W];

    for (genvar k = 0; k < NUM_W; k++) begin : g_stage
        logic [NUM_W-1:0] n_in;
        logic [NUM_W-1:0] q_in;
        logic [DEN_W-1:0] r_in;
        logic [DEN_W-1:0] d_in;
        logic [DEN_W:0]   trial;
        logic [DEN_W:0]   diff;
        logic             take;

        if (k == 0)
        begin : g_first
            assign n_in = num;
            assign q_in = '0;
            assign r_in = '0;
            assign d_in = den;
        end
        else
        begin : g_rest
            assign n_in = n_reg[k-1];
            assign q_in = q_reg[k-1];
            assign r_in = r_reg[k-1];
            assign d_in = d_reg[k-1];
        end

        assign trial = {r_in, n_in[NUM_W-1]};
        assign take  = trial >= {1'b0, d_in};
        assign diff  = trial - {1'b0, d_in};

        always_ff @(posedge clk)
        begin
            n_reg[k] <= n_in << 1;
            q_reg[k] <= {q_in[NUM_W-2:0], take};
            r_reg[k] <= take ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
            d_reg[k] <= d_in;
        end
    end

    assign quo = q_reg[NUM_W-1];

endmodule

`default_nettype wire

// ===== rtl/vector3_alu.sv =====
// Top level of the Q-format three-component vector unit.
//
// One request per clock: a request is taken at every edge with start high
// (busy is always low), and its result appears on rsp with done high for one
// cycle, in request order. The receiver cannot stall. All opcodes share one
// fixed-latency pipe: input register, 32x32 products (six multipliers),
// product sums, rounding and saturation, a 32-stage square-root pipe for
// normalize, divisor setup, then three parallel restoring dividers of
// FRAC_BITS+33 stages (one quotient bit per stage), which set the latency.
// Products round to nearest with ties up; quotients round to nearest with
// ties away from zero. Divide by zero gives full scale with the numerator's
// sign (0 for 0/0) and div_zero; saturation sets overflow. Normalize of a
// zero vector passes it through and never flags.
`default_nettype none

module vector3_alu
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    output logic    busy,
    input  v3_req_t req,
    output logic    done,
    output v3_rsp_t rsp
);

    localparam int NUM_W   = 32 + FRAC_BITS + 1;   // |num|<<F plus rounding term
    localparam int DEN_W   = 33;                   // up to 2^32 for the length
    localparam int TOTAL   = 6 + SQRT_STAGES + NUM_W;

    localparam logic signed [65:0] HALF  = 66'sd1 <<< (FRAC_BITS - 1);
    localparam logic signed [65:0] MAX66 = 66'sd2147483647;
    localparam logic signed [65:0] MIN66 = -66'sd2147483648;
    localparam logic [31:0]        MAXV  = 32'h7FFF_FFFF;
    localparam logic [31:0]        MINV  = 32'h8000_0000;

    // valid bit per stage
    logic [TOTAL-1:0] vld_reg;
    logic [TOTAL-1:0] vld_next;

    assign vld_next = {vld_reg[TOTAL-2:0], start};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    assign busy = 1'b0;
    assign done = vld_reg[TOTAL-1];

    // ---------------- stage 0: input register
    v3_req_t in0_reg;

    always_ff @(posedge clk)
    begin
        in0_reg <= req;
    end

    logic signed [31:0] av [3];
    logic signed [31:0] bv [3];

    assign av[0] = in0_reg.ax;
    assign av[1] = in0_reg.ay;
    assign av[2] = in0_reg.az;
    assign bv[0] = in0_reg.bx;
    assign bv[1] = in0_reg.by_comp;
    assign bv[2] = in0_reg.bz;

    // ---------------- stage 1: products and add/sub
    logic signed [31:0] m1a [3];
    logic signed [31:0] m1b [3];
    logic signed [31:0] m2a [3];
    logic signed [31:0] m2b [3];
    logic signed [63:0] p1_reg [3];
    logic signed [63:0] p2_reg [3];
    logic signed [32:0] as_reg [3];
    v3_pl_t             pl1_next;
    v3_pl_t             pl1_reg;

    for (genvar i = 0; i < 3; i++) begin : g_mul
        localparam int J = (i + 1) % 3;
        localparam int K = (i + 2) % 3;

        always_comb
        begin
            m1a[i] = av[i];
            m1b[i] = bv[i];
            m2a[i] = '0;
            m2b[i] = '0;
            unique case (in0_reg.func)
                OP_CROSS:
                begin
                    m1a[i] = av[J];
                    m1b[i] = bv[K];
                    m2a[i] = av[K];
                    m2b[i] = bv[J];
                end
                OP_SCALE: m1b[i] = in0_reg.scalar;
                OP_NORM:  m1b[i] = av[i];
                default:  ;
            endcase
        end

        always_ff @(posedge clk)
        begin
            p1_reg[i] <= m1a[i] * m1b[i];
            p2_reg[i] <= m2a[i] * m2b[i];
            if (in0_reg.func == OP_SUB)
            begin
                as_reg[i] <= 33'(av[i]) - 33'(bv[i]);
            end
            else
            begin
                as_reg[i] <= 33'(av[i]) + 33'(bv[i]);
            end
        end
    end

    always_comb
    begin
        pl1_next      = '0;
        pl1_next.func = in0_reg.func;
        pl1_next.a    = {in0_reg.az, in0_reg.ay, in0_reg.ax};
        pl1_next.s    = in0_reg.scalar;
    end

    always_ff @(posedge clk)
    begin
        pl1_reg <= pl1_next;
    end

    // ---------------- stage 2: exact sums
    logic signed [65:0] sum_next [3];
    logic signed [65:0] sum_reg  [3];
    v3_pl_t             pl2_reg;

    always_comb
    begin
        for (int i = 0; i < 3; i++)
        begin
            case (pl1_reg.func) inside
                OP_ADD, OP_SUB: sum_next[i] = 66'(as_reg[i]);
                OP_CROSS:       sum_next[i] = 66'(p1_reg[i]) - 66'(p2_reg[i]);
                OP_SCALE:       sum_next[i] = 66'(p1_reg[i]);
                default:        sum_next[i] = '0;
            endcase
        end
        // dot and sum of squares land in lane 0
        if (pl1_reg.func == OP_DOT || pl1_reg.func == OP_NORM)
        begin
            sum_next[0] = 66'(p1_reg[0]) + 66'(p1_reg[1]) + 66'(p1_reg[2]);
        end
    end

    always_ff @(posedge clk)
    begin
        sum_reg <= sum_next;
        pl2_reg <= pl1_reg;
    end

    // ---------------- stage 3: round, saturate; seeds the root pipe
    logic [63:0] sq_x_reg   [SQRT_STAGES+1];
    logic [63:0] sq_res_reg [SQRT_STAGES+1];
    v3_pl_t      sq_pl_reg  [SQRT_STAGES+1];
    v3_pl_t      pl3_next;

    always_comb
    begin
        logic signed [65:0] v;
        pl3_next = pl2_reg;
        pl3_next.ov = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (pl2_reg.func == OP_ADD || pl2_reg.func == OP_SUB)
            begin
                v = sum_reg[i];
            end
            else
            begin
                v = (sum_reg[i] + HALF) >>> FRAC_BITS;
            end
            if (v > MAX66)
            begin
                pl3_next.r[i] = MAXV;
                pl3_next.ov   = 1'b1;
            end
            else if (v < MIN66)
            begin
                pl3_next.r[i] = MINV;
                pl3_next.ov   = 1'b1;
            end
            else
            begin
                pl3_next.r[i] = v[31:0];
            end
        end
        pl3_next.sq_zero = sum_reg[0][63:0] == 64'd0;
    end

    always_ff @(posedge clk)
    begin
        sq_x_reg[0]   <= sum_reg[0][63:0];
        sq_res_reg[0] <= '0;
        sq_pl_reg[0]  <= pl3_next;
    end

    // ---------------- square root, one result bit per stage
    for (genvar k = 0; k < SQRT_STAGES; k++) begin : g_sqrt
        localparam logic [63:0] SQ_BIT = 64'd1 << (62 - 2 * k);
        logic [63:0] trial;
        logic        take;

        assign trial = sq_res_reg[k] + SQ_BIT;
        assign take  = sq_x_reg[k] >= trial;

        always_ff @(posedge clk)
        begin
            sq_x_reg[k+1]   <= take ? sq_x_reg[k] - trial : sq_x_reg[k];
            sq_res_reg[k+1] <= take ? (sq_res_reg[k] >> 1) + SQ_BIT : sq_res_reg[k] >> 1;
            sq_pl_reg[k+1]  <= sq_pl_reg[k];
        end
    end

    // ---------------- divisor setup
    logic [DEN_W-1:0] len;
    logic [NUM_W-1:0] dn_next [3];
    logic [DEN_W-1:0] dd_next [3];
    logic [NUM_W-1:0] dn_reg  [3];
    logic [DEN_W-1:0] dd_reg  [3];
    v3_pl_t           dp_next;
    v3_pl_t           dv_pl_reg [NUM_W+1];

    // round to nearest: the leftover of the root is compared with the root
    assign len = DEN_W'(sq_res_reg[SQRT_STAGES])
               + DEN_W'(sq_x_reg[SQRT_STAGES] > sq_res_reg[SQRT_STAGES]);

    always_comb
    begin
        logic [31:0]      num;
        logic [31:0]      nmag;
        logic [DEN_W-1:0] dmag;
        logic             dneg;
        dp_next = sq_pl_reg[SQRT_STAGES];
        for (int i = 0; i < 3; i++)
        begin
            case (dp_next.func)
                OP_S_DIV:
                begin
                    num  = dp_next.s;
                    dmag = DEN_W'(dp_next.a[i][31] ? 32'(-dp_next.a[i]) : dp_next.a[i]);
                    dneg = dp_next.a[i][31];
                end
                OP_NORM:
                begin
                    num  = dp_next.a[i];
                    dmag = len;
                    dneg = 1'b0;
                end
                default:
                begin
                    num  = dp_next.a[i];
                    dmag = DEN_W'(dp_next.s[31] ? 32'(-dp_next.s) : dp_next.s);
                    dneg = dp_next.s[31];
                end
            endcase
            nmag = num[31] ? 32'(-num) : num;
            dn_next[i] = NUM_W'({nmag, {FRAC_BITS{1'b0}}}) + NUM_W'(dmag >> 1);
            dd_next[i] = dmag;
            dp_next.neg[i]      = num[31] ^ dneg;
            dp_next.num_neg[i]  = num[31];
            dp_next.num_zero[i] = num == 32'd0;
            dp_next.den_zero[i] = dmag == '0;
        end
    end

    always_ff @(posedge clk)
    begin
        dn_reg       <= dn_next;
        dd_reg       <= dd_next;
        dv_pl_reg[0] <= dp_next;
    end

    // ---------------- three divider lanes
    logic [NUM_W-1:0] quo [3];

    for (genvar i = 0; i < 3; i++) begin : g_div
        v3alu_div_lane #(
            .NUM_W (NUM_W),
            .DEN_W (DEN_W)
        ) u_div (
            .clk (clk),
            .num (dn_reg[i]),
            .den (dd_reg[i]),
            .quo (quo[i])
        );
    end

    for (genvar k = 0; k < NUM_W; k++) begin : g_dvpl
        always_ff @(posedge clk)
        begin
            dv_pl_reg[k+1] <= dv_pl_reg[k];
        end
    end

    // ---------------- result select and output register
    v3_pl_t  fin;
    v3_rsp_t rsp_next;
    v3_rsp_t rsp_reg;

    assign fin = dv_pl_reg[NUM_W];

    always_comb
    begin
        logic [2:0][31:0] qv;
        logic             dz;
        logic             ov;
        dz = 1'b0;
        ov = 1'b0;
        for (int i = 0; i < 3; i++)
        begin
            if (fin.den_zero[i])
            begin
                dz = 1'b1;
                if (fin.num_zero[i])
                begin
                    qv[i] = '0;
                end
                else
                begin
                    qv[i] = fin.num_neg[i] ? MINV : MAXV;
                end
            end
            else if (fin.neg[i])
            begin
                if (quo[i] > NUM_W'(MINV))
                begin
                    qv[i] = MINV;
                    ov    = 1'b1;
                end
                else
                begin
                    qv[i] = 32'd0 - quo[i][31:0];
                end
            end
            else
            begin
                if (quo[i] > NUM_W'(MAXV))
                begin
                    qv[i] = MAXV;
                    ov    = 1'b1;
                end
                else
                begin
                    qv[i] = quo[i][31:0];
                end
            end
        end

        case (fin.func) inside
            OP_DIV_S, OP_S_DIV:
            begin
                rsp_next = {qv[0], qv[1], qv[2], dz, ov};
            end
            OP_NORM:
            begin
                if (fin.sq_zero)
                begin
                    rsp_next = {fin.a[0], fin.a[1], fin.a[2], 1'b0, 1'b0};
                end
                else
                begin
                    rsp_next = {qv[0], qv[1], qv[2], 1'b0, 1'b0};
                end
            end
            default:
            begin
                rsp_next = {fin.r[0], fin.r[1], fin.r[2], 1'b0, fin.ov};
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        rsp_reg <= rsp_next;
    end

    assign rsp = rsp_reg;

    // ---------------- checks
    a_done_has_request: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, TOTAL))
        else $error("result without a request");

    a_dz_only_div: assert property (@(posedge clk) disable iff (!rst_n)
        done && rsp.div_zero |->
            ($past(req.func, TOTAL) == OP_DIV_S || $past(req.func, TOTAL) == OP_S_DIV))
        else $error("div_zero on a non-divide op");

    a_norm_no_flags: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(req.func, TOTAL) == OP_NORM |-> !rsp.div_zero && !rsp.overflow)
        else $error("normalize raised a flag");

    a_dot_clears_yz: assert property (@(posedge clk) disable iff (!rst_n)
        done && $past(req.func, TOTAL) == OP_DOT |-> rsp.ry == '0 && rsp.rz == '0)
        else $error("dot left ry or rz nonzero");

endmodule

`default_nettype wire

// ===== bench/v3alu_checker.sv =====
// Checker for the vector unit: predicts each request's result and compares it with the output.
module v3alu_checker
    import v3alu_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    start,
    input  logic    busy,
    input  v3_req_t req,
    input  logic    done,
    input  v3_rsp_t rsp,
    output int      fail_count,
    output int      pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam longint MAX32 = 64'sd2147483647;
    localparam longint MIN32 = -64'sd2147483648;

    v3_rsp_t expected_rsps[$];

    assign pending = expected_rsps.size();

    function automatic longint clamp32(input longint v, inout bit ov);
        if (v > MAX32)
        begin
            ov = 1'b1;
            return MAX32;
        end
        if (v < MIN32)
        begin
            ov = 1'b1;
            return MIN32;
        end
        return v;
    endfunction

    // Sum of products, each at most 2^62 in magnitude, then round half up: fits a 128-bit sum.
    function automatic longint round_prod(input logic signed [127:0] sum);
        logic signed [127:0] t;
        t = (sum + (128'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS;
        return (t > 128'sd4611686018427387904) ? 64'sd4611686018427387904 :
               (t < -128'sd4611686018427387904) ? -64'sd4611686018427387904 : longint'(t);
    endfunction

    function automatic longint divide_q(input longint num, input longint den,
                                        inout bit dz, inout bit ov);
        logic [127:0] n, d, q;
        bit neg;
        neg = (num < 0) != (den < 0);
        if (den == 0)
        begin
            dz = 1'b1;
            return (num > 0) ? MAX32 : (num < 0) ? MIN32 : 0;
        end
        n = 128'(num < 0 ? -num : num) << FRAC_BITS;
        d = 128'(den < 0 ? -den : den);
        q = (n + (d >> 1)) / d;
        if (neg)
        begin
            if (q > 128'h8000_0000)
            begin
                ov = 1'b1;
                return MIN32;
            end
            return -longint'(q);
        end
        if (q > 128'h7FFF_FFFF)
        begin
            ov = 1'b1;
            return MAX32;
        end
        return longint'(q);
    endfunction

    function automatic longint root_nearest(input logic [63:0] s);
        logic [63:0] r;
        r = 0;
        for (int b = 31; b >= 0; b--)
        begin
            logic [63:0] t;
            t = r | (64'd1 << b);
            if (t * t <= s)
                r = t;
        end
        if (s - r * r > r)
            r = r + 1;
        return longint'(r);
    endfunction

    function automatic v3_rsp_t predict_vector(input v3_req_t q);
        longint a[3], b[3], s, r[3];
        bit dz, ov, dzn, ovn;
        logic [63:0] sq;
        longint len;
        v3_rsp_t o;
        a[0] = q.ax; a[1] = q.ay; a[2] = q.az;
        b[0] = q.bx; b[1] = q.by_comp; b[2] = q.bz;
        s = q.scalar;
        r = '{0, 0, 0};
        dz = 0; ov = 0; dzn = 0; ovn = 0;
        case (q.func)
            OP_ADD: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] + b[i], ov);
            OP_SUB: for (int i = 0; i < 3; i++) r[i] = clamp32(a[i] - b[i], ov);
            OP_DOT:
                r[0] = clamp32(round_prod(128'(a[0] * b[0]) + 128'(a[1] * b[1])
                                          + 128'(a[2] * b[2])), ov);
            OP_CROSS:
                for (int i = 0; i < 3; i++)
                    r[i] = clamp32(round_prod(128'(a[(i+1)%3] * b[(i+2)%3])
                                              - 128'(a[(i+2)%3] * b[(i+1)%3])), ov);
            OP_SCALE: for (int i = 0; i < 3; i++) r[i] = clamp32(round_prod(128'(a[i] * s)), ov);
            OP_DIV_S: for (int i = 0; i < 3; i++) r[i] = divide_q(a[i], s, dz, ov);
            OP_S_DIV: for (int i = 0; i < 3; i++) r[i] = divide_q(s, a[i], dz, ov);
            default:
            begin
                sq = 64'(a[0] * a[0]) + 64'(a[1] * a[1]) + 64'(a[2] * a[2]);
                if (sq == 0)
                    r = a;
                else
                begin
                    len = root_nearest(sq);
                    // normalize never flags
                    for (int i = 0; i < 3; i++) r[i] = divide_q(a[i], len, dzn, ovn);
                end
            end
        endcase
        o.rx = r[0][31:0];
        o.ry = r[1][31:0];
        o.rz = r[2][31:0];
        o.div_zero = dz;
        o.overflow = ov;
        return o;
    endfunction

    task automatic report_mismatch(input string what, input v3_rsp_t got, input v3_rsp_t want);
        $display("MISMATCH %s: got %h/%h/%h dz%0b ov%0b want %h/%h/%h dz%0b ov%0b", what,
                 got.rx, got.ry, got.rz, got.div_zero, got.overflow,
                 want.rx, want.ry, want.rz, want.div_zero, want.overflow);
        fail_count++;
    endtask

    initial fail_count = 0;

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (done)
            begin
                if (expected_rsps.size() == 0)
                    report_mismatch("unexpected result", rsp, '0);
                else
                begin
                    v3_rsp_t want;
                    want = expected_rsps.pop_front();
                    if (rsp.rx !== want.rx || rsp.ry !== want.ry || rsp.rz !== want.rz ||
                        rsp.div_zero !== want.div_zero || rsp.overflow !== want.overflow)
                        report_mismatch("field", rsp, want);
                end
            end
            if (start && !busy)
                expected_rsps.push_back(predict_vector(req));
        end
    end
endmodule

// ===== bench/tb_top.sv =====
// Testbench top: drives vector requests into vector3_alu and gives the verdict.
module tb_top
    import v3alu_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int LATENCY  = 87;
    localparam int LIMIT    = 400000;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    start = 1'b0;
    logic    busy;
    logic    done;
    v3_req_t req = '0;
    v3_rsp_t rsp;
    int      fail_count;
    int      pending;
    int      cycles = 0;
    int      idle_pct = 0;

    always #10 clk = ~clk;

    vector3_alu dut (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .req   (req),
        .done  (done),
        .rsp   (rsp)
    );

    v3alu_checker checker_i (
        .clk        (clk),
        .rst_n      (rst_n),
        .start      (start),
        .busy       (busy),
        .req        (req),
        .done       (done),
        .rsp        (rsp),
        .fail_count (fail_count),
        .pending    (pending)
    );

    // Watchdog: a hung pipe or lost result ends the run here.
    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > LIMIT)
        begin
            $display("Some tests failed");
            $finish;
        end
    end

    // Component mix: extremes, small values and full-range noise.
    function automatic logic [31:0] pick_comp();
        case ($urandom_range(0, 9))
            0: return 32'h8000_0000;
            1: return 32'h7FFF_FFFF;
            2: return 32'h0;
            3: return 32'($signed($urandom_range(0, 8)) - 4) << 16;
            4, 5: return 32'($signed($urandom_range(0, 1024)) - 512) <<< 12;
            6: return 32'($signed($urandom_range(0, 131072)) - 65536);
            default: return $urandom;
        endcase
    endfunction

    // Hold start until the request is taken; sender idles idle_pct percent.
    task automatic send_request(input v3_req_t q);
        while ($urandom_range(0, 99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        req   <= q;
        start <= 1'b1;
        @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    function automatic v3_req_t make_request(input op_t f, input logic [31:0] a0, a1, a2,
                                             b0, b1, b2, s);
        v3_req_t q;
        q.func = f; q.ax = a0; q.ay = a1; q.az = a2;
        q.bx = b0; q.by_comp = b1; q.bz = b2; q.scalar = s;
        return q;
    endfunction

    initial
    begin
        v3_req_t q;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed: every op at the extremes, zero divisors, zero normalize.
        for (int f = 0; f < 8; f++)
            send_request(make_request(op_t'(f), 32'h7FFF_FFFF, 32'h8000_0000, 32'h0001_0000,
                                      32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000,
                                      32'h8000_0000));
        send_request(make_request(OP_DIV_S, 32'h0003_0000, 32'hFFFF_0000, 32'h0, 0, 0, 0, 32'h0));
        send_request(make_request(OP_S_DIV, 32'h0, 32'h0002_0000, 32'h0, 0, 0, 0, 32'h0005_0000));
        send_request(make_request(OP_S_DIV, 32'h0, 32'h0, 32'h0, 0, 0, 0, 32'hFFFB_0000));
        send_request(make_request(OP_S_DIV, 32'h0, 32'h0, 32'h0001_0000, 0, 0, 0, 32'h0));
        send_request(make_request(OP_NORM, 32'h0, 32'h0, 32'h0, 1, 2, 3, 4));
        send_request(make_request(OP_NORM, 32'h0003_0000, 32'h0004_0000, 32'h0, 0, 0, 0, 0));
        send_request(make_request(OP_NORM, 32'h0, 32'h0, 32'h8000_0000, 0, 0, 0, 0));
        send_request(make_request(OP_NORM, 32'h0, 32'h0000_0001, 32'h0, 0, 0, 0, 0));
        send_request(make_request(OP_SCALE, 32'h0000_8000, 32'hFFFF_8000, 32'h1,
                                  0, 0, 0, 32'h0000_0001));
        send_request(make_request(OP_DOT, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                                  32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 0));
        send_request(make_request(OP_DIV_S, 32'h0000_0001, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                  0, 0, 0, 32'h0000_0003));

        // Random phases: none, sender idle 67%, 67% (receiver stall n/a), both 21%.
        for (int ph = 0; ph < 4; ph++)
        begin
            idle_pct = (ph == 0) ? 0 : (ph == 3) ? 21 : 67;
            for (int n = 0; n < 490; n++)
            begin
                q = make_request(op_t'($urandom_range(0, 7)), pick_comp(), pick_comp(),
                                 pick_comp(), pick_comp(), pick_comp(), pick_comp(),
                                 pick_comp());
                send_request(q);
            end
        end
        start <= 1'b0;

        while (pending != 0)
            @(posedge clk);
        repeat (LATENCY) @(posedge clk);
        if (fail_count == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end
endmodule
